// File: rtl/core/lacq_pkg.sv
// Package for the line-assembling circular queue.
// Holds the geometry constants, command and status codes, and the beat and control structs.
// No dependencies; lacq_ctrl, lacq_dpath and the top level import it.
package lacq_pkg;

	localparam int unsigned ROWS     = 16;
	localparam int unsigned LINE_LEN = 128;
	localparam int unsigned DEPTH    = ROWS * LINE_LEN;

	localparam int unsigned SLOT_W = $clog2(ROWS);
	localparam int unsigned COL_W  = $clog2(LINE_LEN + 1);
	localparam int unsigned CNT_W  = $clog2(ROWS + 1);
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	localparam logic [7:0] NEWLINE = 8'h0A;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_LONG  = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] byte_in;
		logic [3:0] read_slot;
		logic [6:0] read_column;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] line_slot;
		logic [7:0] read_byte;
		logic [4:0] line_count;
		logic       is_full;
		logic       is_empty;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // request beat taken this cycle
		logic load_now;   // result of a non-read beat goes to the output register
		logic load_read;  // read data has arrived and goes to the output register
	} ctl_t;

endpackage

// File: rtl/core/line_assembling_circular_queue.sv
// Top level of the line-assembling circular queue.
// Depends on lacq_pkg, lacq_ctrl, lacq_dpath and lacq_ram.
//
// Channel  Handshake             Payload
// req      req_valid/req_stall   req   (lacq_pkg::req_t)
// rsp      rsp_valid/rsp_stall   rsp   (lacq_pkg::rsp_t)
//
// Push, pop and peek beats may follow back to back when the response side does not stall.
// A read goes through the registered read port of the line store and a wait state, in which no new beat is taken.
// Reset clears the pointers, column and line count; the store keeps whatever it held.
// While a result waits in the output register under stall, no new beat is taken.
module line_assembling_circular_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  lacq_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lacq_pkg::rsp_t   rsp
);
	import lacq_pkg::*;

	ctl_t ctl;

	lacq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_cmd  (req.cmd),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.ctl      (ctl)
	);

	lacq_dpath u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

// File: rtl/core/lacq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the width and depth come from its parameters.
module lacq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/lacq_ctrl.sv
// Controller for the line-assembling circular queue: handshakes and the read wait state.
// Depends on lacq_pkg; drives lacq_dpath through a ctl_t command struct.
module lacq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_cmd,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output lacq_pkg::ctl_t    ctl
);
	import lacq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic accept;

	// Outside the read wait state, a new beat may enter while the output register is empty or is being emptied.
	assign req_stall = (state_q == S_READ) || (out_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	assign ctl.accept    = accept;
	assign ctl.load_now  = accept && (req_cmd != CMD_READ);
	assign ctl.load_read = (state_q == S_READ);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (req_cmd == CMD_READ)) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_now || ctl.load_read) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// File: rtl/core/lacq_dpath.sv
// Datapath for the line-assembling circular queue: ring pointers, line store and result register.
// Depends on lacq_pkg and lacq_ram; is steered by the ctl_t commands of lacq_ctrl.
module lacq_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  lacq_pkg::ctl_t   ctl,
	input  lacq_pkg::req_t   req,
	output lacq_pkg::rsp_t   rsp
);
	import lacq_pkg::*;

	logic [SLOT_W-1:0] oldest_q;
	logic [SLOT_W-1:0] last_q;
	logic [COL_W-1:0]  col_q;
	logic [CNT_W-1:0]  count_q;
	logic              rd_ok_s1;
	rsp_t              rsp_q;

	logic [SLOT_W-1:0] wslot;
	logic [SLOT_W-1:0] oldest_next;
	logic              full;
	logic              empty;
	logic              col_room;
	logic              is_nl;
	logic              do_push;
	logic              do_pop;
	logic              rd_ok;
	logic              ram_we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        ram_rdata;
	logic [CNT_W-1:0]  count_d;
	rsp_t              now_rsp;
	rsp_t              rd_rsp;

	assign full     = (count_q == CNT_W'(ROWS));
	assign empty    = (count_q == '0);
	assign col_room = (col_q < COL_W'(LINE_LEN));
	assign is_nl    = (req.byte_in == NEWLINE);

	assign wslot       = (last_q == SLOT_W'(ROWS - 1)) ? '0 : last_q + 1'b1;
	assign oldest_next = (oldest_q == SLOT_W'(ROWS - 1)) ? '0 : oldest_q + 1'b1;

	assign do_push = ctl.accept && (req.cmd == CMD_PUSH) && !full;
	assign do_pop  = ctl.accept && (req.cmd == CMD_POP) && !empty;
	assign ram_we  = do_push && col_room;

	assign waddr = ADDR_W'(wslot) * ADDR_W'(LINE_LEN) + ADDR_W'(col_q);

	assign rd_ok = (32'(req.read_slot) < ROWS) && (32'(req.read_column) < LINE_LEN);
	assign raddr = rd_ok ? ADDR_W'(req.read_slot) * ADDR_W'(LINE_LEN)
		+ ADDR_W'(req.read_column) : '0;

	lacq_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(req.byte_in),
		.re   (ctl.accept && (req.cmd == CMD_READ)),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		count_d = count_q;
		if (do_push && is_nl) begin
			count_d = count_q + 1'b1;
		end else if (do_pop) begin
			count_d = count_q - 1'b1;
		end
	end

	always_comb begin
		now_rsp            = '0;
		now_rsp.line_count = count_d;
		now_rsp.is_full    = (count_d == CNT_W'(ROWS));
		now_rsp.is_empty   = (count_d == '0);
		case (req.cmd) inside
			CMD_PUSH: begin
				if (full) begin
					now_rsp.status = ST_FULL;
				end else if (!col_room) begin
					now_rsp.status = ST_LONG;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (empty) begin
					now_rsp.status = ST_EMPTY;
				end else begin
					now_rsp.line_slot = 4'(oldest_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rd_rsp            = '0;
		rd_rsp.read_byte  = rd_ok_s1 ? ram_rdata : 8'h00;
		rd_rsp.line_count = count_q;
		rd_rsp.is_full    = full;
		rd_rsp.is_empty   = empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			last_q   <= SLOT_W'(ROWS - 1);
			col_q    <= '0;
			count_q  <= '0;
		end else begin
			count_q <= count_d;
			if (do_push) begin
				// A newline closes the line even when it no longer fits.
				if (is_nl) begin
					col_q  <= '0;
					last_q <= wslot;
				end else if (col_room) begin
					col_q <= col_q + 1'b1;
				end
			end
			if (do_pop) begin
				oldest_q <= oldest_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd_ok_s1 <= rd_ok;
		end
		if (ctl.load_now) begin
			rsp_q <= now_rsp;
		end else if (ctl.load_read) begin
			rsp_q <= rd_rsp;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: tb/tb_line_assembling_circular_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the line-assembling circular queue.
// Needs lacq_pkg and the RTL under rtl/core. It predicts every response beat and
// compares it with the beat the block returns.
module tb_line_assembling_circular_queue;
	import lacq_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_BEATS = 700;
	localparam int unsigned CALM_TAIL    = 100;
	localparam int unsigned HOLD_AFTER   = 150;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned PAUSE_AT     = 400;

	typedef struct packed {
		logic drain;
		req_t beat;
	} stim_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Shadow of the queue state, advanced once per accepted request beat.
	logic [7:0]  store_mem [0:DEPTH-1];
	bit          written [0:DEPTH-1];
	int unsigned written_addr [$];
	int unsigned oldest_m  = 0;
	int unsigned last_wr_m = ROWS - 1;
	int unsigned column_m  = 0;
	int unsigned lines_m   = 0;

	stim_t       backlog [$];
	rsp_t        rsp_due [$];
	int unsigned beats_in    = 0;
	int unsigned results_out = 0;
	int unsigned gap_left    = 0;
	int unsigned stall_left  = 0;
	int unsigned hold_left   = 0;
	bit          held        = 1'b0;
	bit          calm        = 1'b0;
	bit          drv_idle_on = 1'b1;
	bit          rcv_idle_on = 1'b1;
	int          errors      = 0;

	line_assembling_circular_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic queue_step(input req_t b, output rsp_t r);
		int unsigned wslot;
		int unsigned addr;
		r = '0;
		case (b.cmd)
			CMD_PUSH: begin
				if (lines_m >= ROWS) begin
					r.status = ST_FULL;
				end else begin
					wslot = (last_wr_m + 1) % ROWS;
					if (column_m < LINE_LEN) begin
						addr = wslot * LINE_LEN + column_m;
						store_mem[addr] = b.byte_in;
						if (!written[addr]) begin
							written[addr] = 1'b1;
							written_addr.push_back(addr);
						end
						column_m++;
					end else begin
						r.status = ST_LONG;
					end
					// A newline closes the line even when it could not be stored.
					if (b.byte_in == NEWLINE) begin
						lines_m++;
						column_m  = 0;
						last_wr_m = wslot;
					end
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (lines_m == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.line_slot = 4'(oldest_m);
					if (b.cmd == CMD_POP) begin
						oldest_m = (oldest_m + 1) % ROWS;
						lines_m--;
					end
				end
			end
			CMD_READ: begin
				if (b.read_slot < ROWS && b.read_column < LINE_LEN)
					r.read_byte = store_mem[b.read_slot * LINE_LEN + b.read_column];
			end
		endcase
		r.line_count = 5'(lines_m);
		r.is_full    = (lines_m == ROWS);
		r.is_empty   = (lines_m == 0);
	endtask

	task automatic queue_beat(input logic [1:0] c, input logic [7:0] b);
		stim_t s;
		s.drain            = 1'b0;
		s.beat.cmd         = c;
		s.beat.byte_in     = b;
		s.beat.read_slot   = 4'($urandom_range(0, 15));
		s.beat.read_column = 7'($urandom_range(0, 127));
		backlog.push_back(s);
	endtask

	function automatic void check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// Request side: one beat on offer at a time, taken from the backlog.
	always @(posedge clk or negedge arst_n) begin : driver
		stim_t       nxt;
		rsp_t        due;
		int unsigned addr;
		bit          taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if ($urandom_range(0, 39) == 0)
				drv_idle_on <= ($urandom_range(0, 2) != 0);
			taken = req_valid && !req_stall;
			if (taken) begin
				queue_step(req, due);
				rsp_due.push_back(due);
				beats_in <= beats_in + 1;
			end
			if (!req_valid || taken) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (backlog.size() == 0 ||
						(backlog[0].drain && results_out != beats_in + taken)) begin
					req_valid <= 1'b0;
				end else begin
					nxt = backlog.pop_front();
					// The store is undefined until written, so reads only aim at
					// entries that some push has already filled.
					if (nxt.beat.cmd == CMD_READ) begin
						addr = nxt.beat.read_slot * LINE_LEN + nxt.beat.read_column;
						if (!written[addr]) begin
							if (written_addr.size() == 0) begin
								nxt.beat.cmd = CMD_PEEK;
							end else begin
								addr = written_addr[$urandom_range(0, written_addr.size() - 1)];
								nxt.beat.read_slot   = 4'(addr / LINE_LEN);
								nxt.beat.read_column = 7'(addr % LINE_LEN);
							end
						end
					end
					req       <= nxt.beat;
					req_valid <= 1'b1;
					if (!calm && drv_idle_on && $urandom_range(0, 5) == 0)
						gap_left <= $urandom_range(1, 5);
					calm <= (backlog.size() < CALM_TAIL);
				end
			end
		end
	end

	// Response side: checks each beat and applies back-pressure.
	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if ($urandom_range(0, 39) == 0)
				rcv_idle_on <= ($urandom_range(0, 2) != 0);
			if (rsp_valid && !rsp_stall) begin
				results_out <= results_out + 1;
				if (rsp_due.size() == 0) begin
					$display("%0t: response beat with none expected, actual %p", $time, rsp);
					errors++;
				end else begin
					want = rsp_due.pop_front();
					check_field("status", 8'(want.status), 8'(rsp.status));
					check_field("line_slot", 8'(want.line_slot), 8'(rsp.line_slot));
					check_field("read_byte", want.read_byte, rsp.read_byte);
					check_field("line_count", 8'(want.line_count), 8'(rsp.line_count));
					check_field("is_full", 8'(want.is_full), 8'(rsp.is_full));
					check_field("is_empty", 8'(want.is_empty), 8'(rsp.is_empty));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else if (!held && results_out >= HOLD_AFTER) begin
				// One long hold-off, so that the block backs up into its input.
				hold_left <= HOLD_CYCLES;
				held      <= 1'b1;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_stall  <= 1'b1;
			end else if (!calm && rcv_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 4);
				rsp_stall  <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_line_assembling_circular_queue NOT OK");
		$finish;
	end

	initial begin : run
		int unsigned directed;
		int unsigned mode;
		int unsigned push_share;
		int unsigned len;
		int unsigned n;
		logic [7:0]  ch;

		// Directed opening: empty queue, byte extremes, a full ring and a rejected push.
		queue_beat(CMD_POP, 8'h00);
		queue_beat(CMD_PEEK, 8'hFF);
		queue_beat(CMD_PUSH, 8'h00);
		queue_beat(CMD_PUSH, 8'hFF);
		queue_beat(CMD_PUSH, 8'h55);
		queue_beat(CMD_PUSH, 8'hAA);
		queue_beat(CMD_PUSH, NEWLINE);
		queue_beat(CMD_READ, 8'h00);
		repeat (ROWS - 1) queue_beat(CMD_PUSH, NEWLINE);
		queue_beat(CMD_PUSH, 8'hFF);
		queue_beat(CMD_PEEK, 8'h00);
		queue_beat(CMD_POP, 8'h00);
		backlog[7].beat.read_slot   = 4'd0;
		backlog[7].beat.read_column = 7'd3;
		directed = backlog.size();

		// Lines that run past the end of a slot, one of them closed exactly at the end.
		// A pop ahead of each keeps a slot free, so the bytes are not rejected as full.
		for (int k = 0; k < 2; k++) begin
			queue_beat(CMD_POP, 8'h00);
			for (int i = 0; i < LINE_LEN + 2 * (1 - k); i++) begin
				ch = 8'($urandom_range(0, 255));
				queue_beat(CMD_PUSH, (ch == NEWLINE) ? 8'hF5 : ch);
			end
			queue_beat(CMD_PUSH, NEWLINE);
		end

		// Random traffic in phases that fill, drain or balance the ring.
		mode = 0;
		while (backlog.size() < directed + RANDOM_BEATS) begin
			if ($urandom_range(0, 29) == 0)
				mode = $urandom_range(0, 2);
			push_share = (mode == 1) ? 80 : (mode == 2) ? 25 : 55;
			if ($urandom_range(0, 99) < push_share) begin
				len = ($urandom_range(0, 29) == 0) ? $urandom_range(120, 134)
					: $urandom_range(0, 10);
				for (int i = 0; i < len; i++) begin
					ch = 8'($urandom_range(0, 255));
					queue_beat(CMD_PUSH, (ch == NEWLINE) ? 8'hF5 : ch);
				end
				// Now and then a line is left open and the next one runs on into it.
				if ($urandom_range(0, 9) != 0)
					queue_beat(CMD_PUSH, NEWLINE);
			end else begin
				n = $urandom_range(0, 9);
				if (n <= 5) begin
					queue_beat(CMD_POP, 8'($urandom_range(0, 255)));
				end else if (n <= 7) begin
					queue_beat(CMD_PEEK, 8'($urandom_range(0, 255)));
				end else begin
					repeat ($urandom_range(1, 4))
						queue_beat(CMD_READ, 8'($urandom_range(0, 255)));
				end
			end
		end
		// The sender waits here until every outstanding response beat is back.
		backlog[PAUSE_AT].drain = 1'b1;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (backlog.size() != 0 || req_valid || results_out != beats_in);
		repeat (20) @(negedge clk);

		if (rsp_due.size() != 0) begin
			$display("%0t: %0d response beats expected, actual none", $time, rsp_due.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_line_assembling_circular_queue OK");
		else
			$display("tb_line_assembling_circular_queue NOT OK");
		$finish;
	end

endmodule
